// ===== src/nntc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nntc_pkg
// shared constants and payload types of the nearest neighbor classifier
// ----------------------------------------------------------------------------
package nntc_pkg;

  localparam int unsigned MaxRefs  = 1024;
  localparam int unsigned MaxDim   = 128;
  localparam int unsigned RefW     = $clog2(MaxRefs);
  localparam int unsigned DimW     = $clog2(MaxDim);
  localparam int unsigned CntW     = RefW + 1;
  localparam int unsigned DistW    = 39;
  localparam int unsigned TotW     = 32;
  localparam int unsigned CfgDataW = 39;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [1:0] FuncLoad  = 2'd0;
  localparam logic [1:0] FuncQuery = 2'd1;
  localparam logic [1:0] FuncClear = 2'd2;

  localparam logic [1:0] VerdRight = 2'd0;
  localparam logic [1:0] VerdWrong = 2'd1;
  localparam logic [1:0] VerdFar   = 2'd2;
  localparam logic [1:0] VerdNone  = 2'd3;

  localparam logic [CfgIdxW-1:0] RegThreshold = 1'd0;
  localparam logic [CfgIdxW-1:0] RegLength    = 1'd1;

  typedef struct packed {
    logic [1:0]         func;
    logic [15:0]        class_label;
    logic signed [15:0] element;
  } in_item_t;

  typedef struct packed {
    logic [RefW-1:0]  nearest_index;
    logic [15:0]      nearest_label;
    logic [DistW-1:0] nearest_distance;
    logic [1:0]       verdict;
    logic [10:0]      match_right_count;
    logic [10:0]      match_wrong_count;
    logic [10:0]      match_far_count;
    logic [TotW-1:0]  total_right;
    logic [TotW-1:0]  total_wrong;
    logic [TotW-1:0]  total_far;
  } out_item_t;

endpackage

// ===== src/nntc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nntc_if
// valid/ready channel carrying one payload item
// ----------------------------------------------------------------------------
interface nntc_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/nearest_neighbor_threshold_classifier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_threshold_classifier_unit
// squared euclidean nearest neighbor classifier with range threshold
// ----------------------------------------------------------------------------
// usage: items arrive on in_if (func, class_label, element). load items
// (func 0) write one reference element each into the reference memory;
// query items (func 1) fill the query buffer; clear items (func 2) drop the
// store and the totals. the last element of a query starts a scan over every
// stored element: one multiply-accumulate per cycle through the reference
// memory read port. after the scan one result item leaves on out_if;
// the output register holds it while the receiver stalls, and the next input
// item is taken meanwhile unless it would finish another query. reset clears
// counts, positions, totals and the registers; memories need no clearing pass.
// configuration writes use cfg_we_i / cfg_idx_i / cfg_data_i while idle.
// ----------------------------------------------------------------------------
module nearest_neighbor_threshold_classifier_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [nntc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [nntc_pkg::CfgDataW-1:0]   cfg_data_i,
  nntc_if.sink                            in_if,
  nntc_if.source                          out_if
);
  import nntc_pkg::*;

  localparam int unsigned AddrW = RefW + DimW;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StEval = 2'd2;

  // configuration
  logic [DistW-1:0] thresh_q;
  logic [7:0]       vlen_q;
  logic [DimW:0]    len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= DistW'(67108864);
      vlen_q   <= 8'd128;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegThreshold) thresh_q <= cfg_data_i[DistW-1:0];
      else if (cfg_idx_i == RegLength) vlen_q <= cfg_data_i[7:0];
    end
  end

  // effective length: zero acts as one, clipped at the max dimension
  always_comb begin
    if (vlen_q == 8'd0) len = (DimW+1)'(1);
    else if ({1'b0, vlen_q} > 9'(MaxDim)) len = (DimW+1)'(MaxDim);
    else len = (DimW+1)'(vlen_q);
  end

  // memories
  logic signed [15:0] ref_mem [2**AddrW];
  logic [15:0]        lab_mem [MaxRefs];
  logic signed [15:0] qry_mem [MaxDim];

  logic [1:0]       st_q;
  logic [CntW-1:0]  rcnt_q;
  logic [DimW-1:0]  lpos_q, qpos_q;
  logic [TotW-1:0]  tot_q [3];
  logic [15:0]      qlab_q;
  logic             oval_q;
  out_item_t        out_q;

  // scan
  logic [RefW-1:0]  sr_q;      // reference being read
  logic [DimW:0]    se_q;      // element being read
  logic             rv_q;      // read data valid
  logic             rlast_q;   // read was the last element of a reference
  logic [RefW-1:0]  rref_q;
  logic signed [15:0] rdat_q, qdat_q;
  logic [15:0]      rlab_q;
  logic             mv_q, mlast_q;
  logic [RefW-1:0]  mref_q;
  logic [15:0]      mlab_q;
  logic [31:0]      prod_q;
  logic [DistW:0]   acc_q;
  logic             done_issue_q;
  logic [10:0]      nr_q, nw_q, nf_q;
  logic [DistW-1:0] bestd_q;
  logic [RefW-1:0]  best_q;
  logic [15:0]      bestl_q;
  logic             have_q;
  logic [2:0]       drain_q;

  // verdict and saturated totals of the finished query
  logic [1:0]       verd_d;
  logic [TotW-1:0]  tot_d [3];

  logic in_fire, last_q_elem, can_take;
  in_item_t it;
  assign it = in_if.data;
  assign last_q_elem = ({1'b0, qpos_q} + (DimW+1)'(1)) >= len;
  // hold off a finishing query while a result is still waiting
  assign can_take = (st_q == StIdle) &&
                    !(it.func == FuncQuery && last_q_elem && oval_q);
  assign in_if.ready = can_take;
  assign in_fire = in_if.valid && can_take;

  logic room;
  assign room = rcnt_q < CntW'(MaxRefs);

  // memory writes
  always_ff @(posedge clk_i) begin
    if (in_fire && it.func == FuncLoad && room) begin
      ref_mem[{rcnt_q[RefW-1:0], lpos_q}] <= it.element;
      if (({1'b0, lpos_q} + (DimW+1)'(1)) >= len) lab_mem[rcnt_q[RefW-1:0]] <= it.class_label;
    end
    if (in_fire && it.func == FuncQuery) qry_mem[qpos_q] <= it.element;
  end

  // memory reads, one element per cycle
  logic rd_en;
  assign rd_en = (st_q == StScan) && !done_issue_q;
  always_ff @(posedge clk_i) begin
    rdat_q <= ref_mem[{sr_q, se_q[DimW-1:0]}];
    qdat_q <= qry_mem[se_q[DimW-1:0]];
    rlab_q <= lab_mem[sr_q];
  end

  logic signed [16:0] diff;
  logic [16:0] adiff;
  assign diff  = 17'(rdat_q) - 17'(qdat_q);
  assign adiff = diff[16] ? 17'(-diff) : diff;

  logic [DistW:0]   acc_n;
  logic [DistW-1:0] dsat;
  assign acc_n = acc_q + (DistW+1)'(prod_q);
  assign dsat  = acc_n[DistW] ? {DistW{1'b1}} : acc_n[DistW-1:0];

  logic fin_last;
  assign fin_last = (({1'b0, se_q} + (DimW+2)'(1)) >= {1'b0, len});

  always_comb begin
    tot_d[0] = tot_q[0];
    tot_d[1] = tot_q[1];
    tot_d[2] = tot_q[2];
    if (!have_q) verd_d = VerdNone;
    else if (bestd_q > thresh_q) verd_d = VerdFar;
    else if (bestl_q == qlab_q) verd_d = VerdRight;
    else verd_d = VerdWrong;
    case (verd_d)
      VerdRight: if (tot_q[0] != '1) tot_d[0] = tot_q[0] + TotW'(1);
      VerdWrong: if (tot_q[1] != '1) tot_d[1] = tot_q[1] + TotW'(1);
      VerdFar:   if (tot_q[2] != '1) tot_d[2] = tot_q[2] + TotW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; rcnt_q <= '0; lpos_q <= '0; qpos_q <= '0;
      tot_q[0] <= '0; tot_q[1] <= '0; tot_q[2] <= '0;
      qlab_q <= '0; oval_q <= 1'b0; out_q <= '0;
      sr_q <= '0; se_q <= '0; rv_q <= 1'b0; rlast_q <= 1'b0; rref_q <= '0;
      mv_q <= 1'b0; mlast_q <= 1'b0; mref_q <= '0; mlab_q <= '0; prod_q <= '0;
      acc_q <= '0; done_issue_q <= 1'b0; nr_q <= '0; nw_q <= '0; nf_q <= '0;
      bestd_q <= '0; best_q <= '0; bestl_q <= '0; have_q <= 1'b0; drain_q <= '0;
    end else begin
      if (st_q == StEval) oval_q <= 1'b1;
      else if (out_if.valid && out_if.ready) oval_q <= 1'b0;
      // pipeline stage: read -> multiply
      rv_q    <= rd_en;
      rlast_q <= fin_last;
      rref_q  <= sr_q;
      mv_q    <= rv_q;
      mlast_q <= rlast_q;
      mref_q  <= rref_q;
      mlab_q  <= rlab_q;
      prod_q  <= 32'(adiff) * 32'(adiff);
      case (st_q)
        StIdle: begin
          if (in_fire) begin
            case (it.func)
              FuncClear: begin
                rcnt_q <= '0; lpos_q <= '0; qpos_q <= '0;
                tot_q[0] <= '0; tot_q[1] <= '0; tot_q[2] <= '0;
              end
              FuncLoad: begin
                if (({1'b0, lpos_q} + (DimW+1)'(1)) >= len) begin
                  lpos_q <= '0;
                  if (room) rcnt_q <= rcnt_q + CntW'(1);
                end else lpos_q <= lpos_q + DimW'(1);
              end
              FuncQuery: begin
                if (last_q_elem) begin
                  qpos_q <= '0; qlab_q <= it.class_label;
                  sr_q <= '0; se_q <= '0; acc_q <= '0;
                  nr_q <= '0; nw_q <= '0; nf_q <= '0;
                  have_q <= 1'b0; bestd_q <= '0; best_q <= '0; bestl_q <= '0;
                  done_issue_q <= (rcnt_q == '0);
                  drain_q <= '0;
                  st_q <= StScan;
                end else qpos_q <= qpos_q + DimW'(1);
              end
              default: ;
            endcase
          end
        end
        StScan: begin
          if (rd_en) begin
            if (fin_last) begin
              se_q <= '0;
              if (CntW'(sr_q) + CntW'(1) >= rcnt_q) done_issue_q <= 1'b1;
              else sr_q <= sr_q + RefW'(1);
            end else se_q <= se_q + (DimW+1)'(1);
          end
          if (mv_q) begin
            if (mlast_q) begin
              acc_q <= '0;
              if (dsat > thresh_q) nf_q <= nf_q + 11'd1;
              else if (mlab_q == qlab_q) nr_q <= nr_q + 11'd1;
              else nw_q <= nw_q + 11'd1;
              if (!have_q || dsat < bestd_q) begin
                bestd_q <= dsat; best_q <= mref_q; bestl_q <= mlab_q;
              end
              have_q <= 1'b1;
            end else acc_q <= acc_n;
          end
          if (done_issue_q) begin
            drain_q <= drain_q + 3'd1;
            if (drain_q == 3'd3) st_q <= StEval;
          end
        end
        StEval: begin
          out_q.nearest_index     <= have_q ? best_q : '0;
          out_q.nearest_label     <= have_q ? bestl_q : '0;
          out_q.nearest_distance  <= have_q ? bestd_q : '0;
          out_q.match_right_count <= nr_q;
          out_q.match_wrong_count <= nw_q;
          out_q.match_far_count   <= nf_q;
          out_q.verdict           <= verd_d;
          out_q.total_right <= tot_d[0];
          out_q.total_wrong <= tot_d[1];
          out_q.total_far   <= tot_d[2];
          tot_q[0] <= tot_d[0];
          tot_q[1] <= tot_d[1];
          tot_q[2] <= tot_d[2];
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign out_if.valid = oval_q;
  assign out_if.data  = out_q;

endmodule
